@@ hdl/hhsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_pkg
// Shared types, constants and helpers of the HTTP header section parser.
// ----------------------------------------------------------------------------
package hhsp_pkg;

    // Default buffer size in bytes
    localparam int BUFFER_BYTES_DEF = 65536;

    // Register reset values
    localparam logic [7:0]  HDR_CAP_RST     = 8'd32;
    localparam logic [7:0]  NAME_LIMIT_RST  = 8'd64;
    localparam logic [11:0] VALUE_LIMIT_RST = 12'd1024;

    // Register indexes
    localparam logic [1:0] CFG_HDR_CAP     = 2'd0;
    localparam logic [1:0] CFG_NAME_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

    // Character codes
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_LF      = 8'h0a;
    localparam logic [7:0]  CH_CR      = 8'h0d;
    localparam logic [7:0]  CH_SP      = 8'h20;
    localparam logic [7:0]  CH_COLON   = 8'h3a;
    localparam logic [7:0]  CH_DEL     = 8'h7f;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [23:0] TERM_TAIL  = 24'h0d0a0d;

    // Result kinds
    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_REQLINE,
        PH_NAME,
        PH_VALUE,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_BAD   = 2'd1,
        ERR_LARGE = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] name_offset;
        logic [7:0]  name_len;
        logic [15:0] value_offset;
        logic [11:0] value_len;
        logic [7:0]  header_index;
        logic [1:0]  status;
        logic [7:0]  headers_kept;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  hdr_cap;
        logic [7:0]  name_limit;
        logic [11:0] value_limit;
    } t_cfg;

    // RFC 7230 token character
    function automatic logic is_token(input logic [7:0] c);
        logic res;
        case (c) inside
            [8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a,
            8'h2b, 8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

@@ hdl/hhsp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_in_stage
// Input register: holds one byte transaction until the parser core takes it.
// ----------------------------------------------------------------------------
module hhsp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  hhsp_pkg::t_in_item i_data,
    input  logic               i_advance,
    output logic               o_fire,
    output hhsp_pkg::t_in_item o_item
);
    import hhsp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Hold while a byte waits and the core cannot take it
    assign o_stall = r_valid && !i_advance;
    assign o_fire  = r_valid && i_advance;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_data;
        end
    end

endmodule

@@ hdl/hhsp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_core
// Per-byte line scanner: phase state, line bookkeeping and result formation.
// ----------------------------------------------------------------------------
module hhsp_core #(
    parameter int BUFFER_BYTES = hhsp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hhsp_pkg::t_cfg      i_cfg,
    input  logic                i_fire,
    input  hhsp_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output hhsp_pkg::t_out_item o_res
);
    import hhsp_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES);
    localparam int LEN_W = (POS_W > 12) ? POS_W : 12;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);

    t_phase           r_phase, n_phase;
    t_err             r_err, n_err;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [23:0]      r_recent, n_recent;
    logic [POS_W-1:0] r_hdr_start, n_hdr_start;
    logic [7:0]       r_name_cnt, n_name_cnt;
    logic             r_name_ok, n_name_ok;
    logic [POS_W-1:0] r_vfirst, n_vfirst;
    logic [POS_W-1:0] r_vlast, n_vlast;
    logic             r_vseen, n_vseen;
    logic             r_vok, n_vok;
    logic [7:0]       r_stored, n_stored;

    logic [7:0]       b;
    logic [7:0]       prev;
    logic             last;
    logic             term;
    logic             is_lf;
    logic             is_colon;
    logic             reqline_ok;
    logic [LEN_W-1:0] vlen;
    t_err             close_err;

    // ---------------------------------------------------------------- decode
    always_comb begin
        b          = i_item.data_byte;
        prev       = r_recent[7:0];
        last       = i_item.is_last || (r_pos == POS_LAST);
        is_lf      = (b == CH_LF);
        is_colon   = (b == CH_COLON);
        term       = is_lf && (r_recent == TERM_TAIL);
        reqline_ok = (prev == CH_CR) && (r_pos != '0);
        vlen       = r_vseen ? (LEN_W'(r_vlast) - LEN_W'(r_vfirst) + LEN_W'(1)) : '0;
        // Checks in priority order; first failure wins
        if (prev != CH_CR) begin
            close_err = ERR_BAD;
        end else if (r_name_cnt == '0 || !r_name_ok || r_name_cnt >= i_cfg.name_limit) begin
            close_err = ERR_BAD;
        end else if (vlen >= LEN_W'(i_cfg.value_limit)) begin
            close_err = ERR_LARGE;
        end else if (!r_vok) begin
            close_err = ERR_BAD;
        end else if (r_stored >= i_cfg.hdr_cap) begin
            close_err = ERR_LARGE;
        end else begin
            close_err = ERR_NONE;
        end
    end

    // ------------------------------------------------------------ next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            if (r_phase == PH_DONE || term) begin
                n_phase = last ? PH_REQLINE : PH_DONE;
            end else if (last) begin
                n_phase = PH_REQLINE;
            end else if (r_err == ERR_NONE) begin
                case (r_phase)
                    PH_REQLINE: begin
                        if (is_lf && reqline_ok) begin
                            n_phase = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (!is_lf && is_colon) begin
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (is_lf && close_err == ERR_NONE) begin
                            n_phase = PH_NAME;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // ------------------------------------------------- datapath and results
    always_comb begin
        logic             do_clear;
        logic             do_shift;
        logic             do_open;
        logic             v_seen;
        logic [POS_W-1:0] v_first;
        logic [POS_W-1:0] v_last;
        logic             v_ok;

        do_clear = 1'b0;
        do_shift = 1'b0;
        do_open  = 1'b0;
        v_seen   = r_vseen;
        v_first  = r_vfirst;
        v_last   = r_vlast;
        v_ok     = r_vok;

        n_err       = r_err;
        n_pos       = r_pos;
        n_recent    = r_recent;
        n_hdr_start = r_hdr_start;
        n_name_cnt  = r_name_cnt;
        n_name_ok   = r_name_ok;
        n_vfirst    = r_vfirst;
        n_vlast     = r_vlast;
        n_vseen     = r_vseen;
        n_vok       = r_vok;
        n_stored    = r_stored;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            if (r_phase == PH_DONE) begin
                do_clear = last;
                do_shift = !last;
            end else if (term) begin
                o_res_valid        = 1'b1;
                o_res.result_kind  = KIND_STATUS;
                o_res.status       = r_err;
                o_res.headers_kept = r_stored;
                do_clear           = last;
                do_shift           = !last;
            end else if (last) begin
                // No terminator: drop every span of this buffer
                o_res_valid       = 1'b1;
                o_res.result_kind = KIND_STATUS;
                o_res.status      = ERR_BAD;
                do_clear          = 1'b1;
            end else begin
                do_shift = 1'b1;
                if (r_err == ERR_NONE) begin
                    case (r_phase)
                        PH_REQLINE: begin
                            if (is_lf) begin
                                if (reqline_ok) begin
                                    do_open = 1'b1;
                                end else begin
                                    n_err = ERR_BAD;
                                end
                            end
                        end
                        PH_NAME: begin
                            if (is_lf) begin
                                n_err = ERR_BAD;
                            end else if (!is_colon) begin
                                if (r_name_cnt != 8'hff) begin
                                    n_name_cnt = r_name_cnt + 8'd1;
                                end
                                if (!is_token(b)) begin
                                    n_name_ok = 1'b0;
                                end
                            end
                        end
                        PH_VALUE: begin
                            if (is_lf) begin
                                if (close_err != ERR_NONE) begin
                                    n_err = close_err;
                                end else begin
                                    o_res_valid        = 1'b1;
                                    o_res.result_kind  = KIND_SPAN;
                                    o_res.name_offset  = 16'(r_hdr_start);
                                    o_res.name_len     = r_name_cnt;
                                    o_res.value_offset = r_vseen ? 16'(r_vfirst)
                                                                 : 16'(r_pos - POS_W'(1));
                                    o_res.value_len    = 12'(vlen);
                                    o_res.header_index = r_stored;
                                    n_stored           = r_stored + 8'd1;
                                    do_open            = 1'b1;
                                end
                            end else begin
                                // A CR inside the value is a value byte after all
                                if (prev == CH_CR) begin
                                    if (!v_seen) begin
                                        v_first = r_pos - POS_W'(1);
                                    end
                                    v_seen = 1'b1;
                                    v_last = r_pos - POS_W'(1);
                                    v_ok   = 1'b0;
                                end
                                if (b != CH_CR) begin
                                    if (b != CH_SP && b != CH_TAB) begin
                                        if (!v_seen) begin
                                            v_first = r_pos;
                                        end
                                        v_seen = 1'b1;
                                        v_last = r_pos;
                                    end
                                    if ((b < CTRL_LIMIT && b != CH_TAB) || b == CH_DEL) begin
                                        v_ok = 1'b0;
                                    end
                                end
                                n_vseen  = v_seen;
                                n_vfirst = v_first;
                                n_vlast  = v_last;
                                n_vok    = v_ok;
                            end
                        end
                        default: n_err = r_err;
                    endcase
                end
            end

            if (do_shift) begin
                n_recent = {r_recent[15:0], b};
                n_pos    = r_pos + POS_W'(1);
            end
            if (do_open) begin
                n_hdr_start = r_pos + POS_W'(1);
                n_name_cnt  = '0;
                n_name_ok   = 1'b1;
                n_vfirst    = '0;
                n_vlast     = '0;
                n_vseen     = 1'b0;
                n_vok       = 1'b1;
            end
            if (do_clear) begin
                n_err       = ERR_NONE;
                n_pos       = '0;
                n_recent    = '0;
                n_hdr_start = '0;
                n_name_cnt  = '0;
                n_name_ok   = 1'b1;
                n_vfirst    = '0;
                n_vlast     = '0;
                n_vseen     = 1'b0;
                n_vok       = 1'b1;
                n_stored    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_REQLINE;
            r_err       <= ERR_NONE;
            r_pos       <= '0;
            r_recent    <= '0;
            r_hdr_start <= '0;
            r_name_cnt  <= '0;
            r_name_ok   <= 1'b1;
            r_vfirst    <= '0;
            r_vlast     <= '0;
            r_vseen     <= 1'b0;
            r_vok       <= 1'b1;
            r_stored    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_pos       <= n_pos;
            r_recent    <= n_recent;
            r_hdr_start <= n_hdr_start;
            r_name_cnt  <= n_name_cnt;
            r_name_ok   <= n_name_ok;
            r_vfirst    <= n_vfirst;
            r_vlast     <= n_vlast;
            r_vseen     <= n_vseen;
            r_vok       <= n_vok;
            r_stored    <= n_stored;
        end
    end

endmodule

@@ hdl/hhsp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhsp_out_reg
// Result register: holds one result transaction until downstream takes it.
// ----------------------------------------------------------------------------
module hhsp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_res_valid,
    input  hhsp_pkg::t_out_item i_res,
    output logic                o_advance,
    output logic                o_valid,
    input  logic                i_stall,
    output hhsp_pkg::t_out_item o_data
);
    import hhsp_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    // Advance when the register is empty or being drained
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_fire && i_res_valid) begin
            r_data <= i_res;
        end
    end

endmodule

@@ hdl/http_header_section_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_section_parser_top
// HTTP/1.1 header section scanner: one request byte per transaction in,
// header name/value spans and one final status per buffer out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  input     in         i_valid / o_stall          i_data  (t_in_item)
//  result    out        o_valid / i_stall          o_data  (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One byte is taken every cycle while results are not stalled; each result is
//  registered (the byte lands in the input register, then the result
//  register loads from the core's combinational output).
//  The per-byte line bookkeeping in the core sets this byte rate.
//  Reset returns the scanner to the request line and loads register defaults.
//  A stalled result holds the core; one more byte waits in the input register.
// ----------------------------------------------------------------------------
module http_header_section_parser_top #(
    parameter int BUFFER_BYTES = hhsp_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hhsp_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output hhsp_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data
);
    import hhsp_pkg::*;

    t_cfg      r_cfg;
    logic      advance;
    logic      fire;
    t_in_item  item;
    logic      res_valid;
    t_out_item res;

    assign o_cfg_ready = 1'b1;

    // Writes to an unlisted index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_cap     <= HDR_CAP_RST;
            r_cfg.name_limit  <= NAME_LIMIT_RST;
            r_cfg.value_limit <= VALUE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HDR_CAP:     r_cfg.hdr_cap     <= i_cfg_data[7:0];
                CFG_NAME_LIMIT:  r_cfg.name_limit  <= i_cfg_data[7:0];
                CFG_VALUE_LIMIT: r_cfg.value_limit <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    hhsp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .i_advance (advance),
        .o_fire    (fire),
        .o_item    (item)
    );

    hhsp_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fire      (fire),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hhsp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_advance   (advance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
